@@ design/bytebeat_formula_generator_defines.svh @@
// assertion macros for the bytebeat formula generator
`ifndef BYTEBEAT_FORMULA_GENERATOR_DEFINES_SVH
`define BYTEBEAT_FORMULA_GENERATOR_DEFINES_SVH

// generic clocked assertion with asynchronous low reset
`define BFG_ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bytebeat formula generator assertion failed");

// assertion on the block clock and reset
`define BFG_ASSERT(label, prop) \
  `BFG_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ design/bfg_pkg.sv @@
// package with types, codes and helpers of the bytebeat formula generator
package bfg_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_MUL,
    S_FIN
  } state_e;

  localparam logic [3:0] FN_SILENT_A = 4'd0;
  localparam logic [3:0] FN_01       = 4'd1;
  localparam logic [3:0] FN_02       = 4'd2;
  localparam logic [3:0] FN_SILENT_B = 4'd3;
  localparam logic [3:0] FN_04       = 4'd4;
  localparam logic [3:0] FN_05       = 4'd5;
  localparam logic [3:0] FN_06       = 4'd6;
  localparam logic [3:0] FN_07       = 4'd7;
  localparam logic [3:0] FN_08       = 4'd8;
  localparam logic [3:0] FN_09       = 4'd9;
  localparam logic [3:0] FN_FEEDBACK = 4'd10;
  localparam logic [3:0] FN_11       = 4'd11;
  localparam logic [3:0] FN_12       = 4'd12;
  localparam logic [3:0] FN_13       = 4'd13;
  localparam logic [3:0] FN_14       = 4'd14;
  localparam logic [3:0] FN_15       = 4'd15;

  // arithmetic shift right of a 32-bit word
  function automatic logic [31:0] sar32(input logic [31:0] x, input logic [4:0] s);
    return 32'($signed(x) >>> s);
  endfunction

  // number of multiplier passes per formula
  function automatic logic [1:0] num_mul(input logic [3:0] fn, input logic t12);
    logic [1:0] n;
    n = 2'd1;
    unique case (fn)
      FN_SILENT_A, FN_SILENT_B: n = 2'd0;
      FN_05, FN_06, FN_12:      n = 2'd2;
      FN_07:                    n = 2'd3;
      FN_14:                    n = t12 ? 2'd1 : 2'd0;
      default:                  n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

@@ design/bfg_if.sv @@
// request and sample channel interfaces of the bytebeat formula generator
interface bfg_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] time_index;
  logic [3:0]  func;

  modport source (output valid, output time_index, output func, input ready);
  modport sink (input valid, input time_index, input func, output ready);
endinterface

interface bfg_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ design/bfg_mul.sv @@
// shared 32x32 wrapping multiplier with registered product
module bfg_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 32'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

@@ design/bytebeat_formula_generator.sv @@
// Bytebeat formula generator top level: sequencer around one shared multiplier.
// Each request walks the sequencer states: formula 14 with t bit 12 set first runs
// mod-255 byte folding, then each formula makes its multiplier passes (up to 3) in turn.
// A new request is taken once the sequencer is idle, so one request is in flight at a time.
// Reset clears the sequencer, the output valid and the formula 10 feedback value.
`include "bytebeat_formula_generator_defines.svh"
module bytebeat_formula_generator (
  input  logic            clk_i,
  input  logic            rst_ni,
  bfg_in_if.sink          in_i,
  bfg_out_if.source       out_o
);

  bfg_pkg::state_e state_q, state_d;

  logic [30:0] t_q;
  logic [3:0]  fn_q;
  logic [30:0] fx_q;
  logic [1:0]  cnt_q;
  logic [1:0]  nmul_q;
  logic [31:0] pr0_q, pr1_q, pr2_q;
  logic [31:0] fb_q;
  logic        out_valid_q;
  logic [7:0]  sample_q;

  logic [31:0] tt, pp, op_a, op_b, res, fb_next, xs;
  logic [7:0]  rmod;
  logic        in_fire, fin_fire, fb_we, fold_more;

  assign tt        = {1'b0, t_q};
  assign in_fire   = in_i.valid && in_i.ready;
  assign fin_fire  = (state_q == bfg_pkg::S_FIN) && (!out_valid_q || out_o.ready);
  assign fb_we     = fin_fire && (fn_q == bfg_pkg::FN_FEEDBACK);
  assign fold_more = fx_q > 31'd255;
  assign rmod      = (fx_q[7:0] == 8'hFF) ? 8'd0 : fx_q[7:0];
  assign xs        = (tt >> 15) | (tt >> 8);

  bfg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (pp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfg_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_i.func == bfg_pkg::FN_14 && in_i.time_index[12]) state_d = bfg_pkg::S_FOLD;
          else state_d = bfg_pkg::S_MUL;
        end
      end
      bfg_pkg::S_FOLD: begin
        if (!fold_more) state_d = bfg_pkg::S_MUL;
      end
      bfg_pkg::S_MUL: begin
        if (cnt_q == nmul_q) state_d = bfg_pkg::S_FIN;
      end
      bfg_pkg::S_FIN: begin
        if (fin_fire) state_d = bfg_pkg::S_IDLE;
      end
      default: state_d = bfg_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready = (state_q == bfg_pkg::S_IDLE);
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  // multiplier operands per formula and pass
  always_comb begin
    op_a = tt;
    op_b = 32'd0;
    unique case (fn_q)
      bfg_pkg::FN_01: op_b = ((tt >> 12) | (tt >> 8)) & 32'd63 & (tt >> 4);
      bfg_pkg::FN_02: op_b = ((tt >> 5) | (tt >> 8)) >> tt[20:16];
      bfg_pkg::FN_04: op_b = ((tt >> 9) | (tt >> 13)) & 32'd25 & (tt >> 6);
      bfg_pkg::FN_05: begin
        if (cnt_q == 2'd0) op_b = 32'd123;
        else op_b = (tt >> 11) & (tt >> 8) & bfg_pkg::sar32(pp, 5'd3);
      end
      bfg_pkg::FN_06: begin
        if (cnt_q == 2'd0) begin
          op_a = tt >> 19;
          op_b = 32'd5;
        end else begin
          op_b = (tt >> {xs[1:0], 3'b000})
               & (32'd20 | (pp >> tt[4:0]) | (tt >> 3));
        end
      end
      bfg_pkg::FN_07: begin
        unique case (cnt_q)
          2'd0:    op_b = tt & (tt >> 13);
          2'd1: begin
            op_a = (32'd0 - tt) & 32'd4095;
            op_b = pp & 32'd255;
          end
          default: op_b = 32'd234 & (tt >> 8) & (tt >> 3);
        endcase
      end
      bfg_pkg::FN_08: op_b = (tt >> ((tt[13:9] | tt[12:8]))) & 32'd63 & (tt >> 4);
      bfg_pkg::FN_09: begin
        op_a = (tt >> 6) | tt | (tt >> tt[20:16]);
        op_b = 32'd10;
      end
      bfg_pkg::FN_FEEDBACK: op_b = ((tt >> 16) | (tt >> 6)) & (32'd69 & (tt >> 9));
      bfg_pkg::FN_11: op_b = tt | (tt >> 9) | (tt >> 7);
      bfg_pkg::FN_12: op_b = (cnt_q == 2'd0) ? 32'd5 : 32'd3;
      bfg_pkg::FN_13: begin
        op_a = (tt >> 7) | tt | (tt >> 6);
        op_b = 32'd10;
      end
      bfg_pkg::FN_14: op_b = tt ^ {24'd0, rmod};
      bfg_pkg::FN_15: op_b = (tt >> 8) | (tt >> 9);
      default: op_b = 32'd0;
    endcase
  end

  // final combine
  always_comb begin
    fb_next = bfg_pkg::sar32(fb_q, 5'd1) + bfg_pkg::sar32(fb_q, 5'd4) + pr0_q;
    res     = 32'd0;
    unique case (fn_q)
      bfg_pkg::FN_01, bfg_pkg::FN_02, bfg_pkg::FN_04, bfg_pkg::FN_08: res = pr0_q;
      bfg_pkg::FN_05, bfg_pkg::FN_06: res = pr1_q;
      bfg_pkg::FN_07: res = (pr1_q >> 12)
                          + (32'd127 & bfg_pkg::sar32(pr2_q, {3'd0, tt[15:14]}));
      bfg_pkg::FN_09: res = pr0_q + ((tt >> 11) & 32'd7);
      bfg_pkg::FN_FEEDBACK: res = fb_next;
      bfg_pkg::FN_11: res = pr0_q & ((tt >> 11) | (tt >> 9));
      bfg_pkg::FN_12: res = (pr0_q & (tt >> 7))
                          | (pr1_q & bfg_pkg::sar32(tt << 2, 5'd10));
      bfg_pkg::FN_13: res = pr0_q + (((tt & (tt >> 13)) | (tt >> 6)) << 2);
      bfg_pkg::FN_14: begin
        if (tt[12]) res = bfg_pkg::sar32(pr0_q | (tt >> 4), 5'd1);
        else res = (tt >> 3) | (tt[13] ? (tt << 2) : tt);
      end
      bfg_pkg::FN_15: res = (pr0_q & 32'd46 & (tt >> 8)) ^ ((tt & (tt >> 13)) | (tt >> 6));
      default: res = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfg_pkg::S_IDLE;
      cnt_q       <= 2'd0;
      fb_q        <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) cnt_q <= 2'd0;
      else if (state_q == bfg_pkg::S_MUL) cnt_q <= cnt_q + 2'd1;
      if (fb_we) fb_q <= fb_next;
      if (fin_fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      t_q    <= in_i.time_index;
      fn_q   <= in_i.func;
      fx_q   <= in_i.time_index;
      nmul_q <= bfg_pkg::num_mul(in_i.func, in_i.time_index[12]);
    end else if (state_q == bfg_pkg::S_FOLD && fold_more) begin
      fx_q <= (fx_q >> 8) + {23'd0, fx_q[7:0]};
    end
    if (state_q == bfg_pkg::S_MUL) begin
      unique case (cnt_q)
        2'd1:    pr0_q <= pp;
        2'd2:    pr1_q <= pp;
        2'd3:    pr2_q <= pp;
        default: ;
      endcase
    end
    if (fin_fire) sample_q <= res[7:0];
  end

  `BFG_ASSERT(a_busy_after_req, in_fire |=> !in_i.ready)
  `BFG_ASSERT(a_fb_only_f10, !$stable(fb_q) |-> $past(fb_we))
  `BFG_ASSERT(a_result_after_fin, fin_fire |=> out_valid_q && state_q == bfg_pkg::S_IDLE)

endmodule

@@ bench/bytebeat_formula_generator_test.sv @@
// testbench for the bytebeat formula generator with random and directed requests
`timescale 1ns / 1ps
module bytebeat_formula_generator_test;

  typedef struct packed {
    logic [30:0] time_index;
    logic [3:0]  func;
  } request_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bfg_in_if  req_bus ();
  bfg_out_if smp_bus ();

  bytebeat_formula_generator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_bus.sink),
    .out_o (smp_bus.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  request_t          pending_q[$];
  logic signed [7:0] sample_q[$];
  logic [31:0]       echo_state;
  logic              req_taken = 1'b0;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                fail_count;
  int                sample_count;
  int                quiet_cycles;
  int                fn_seen[16];

  function automatic logic [31:0] lsr(input logic [31:0] x, input logic [31:0] n);
    return x >> n[4:0];
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [31:0] n);
    return $signed(x) >>> n[4:0];
  endfunction

  function automatic logic [31:0] bytebeat_value(input logic [31:0] t, input logic [3:0] fn);
    logic [31:0] a;
    logic [31:0] b;
    a = 0;
    b = 0;
    case (fn)
      bfg_pkg::FN_01: a = t * (((t >> 12) | (t >> 8)) & 63 & (t >> 4));
      bfg_pkg::FN_02: a = t * lsr((t >> 5) | (t >> 8), t >> 16);
      bfg_pkg::FN_04: a = t * (((t >> 9) | (t >> 13)) & 25 & (t >> 6));
      bfg_pkg::FN_05: a = t * ((t >> 11) & (t >> 8) & asr(32'd123 * t, 3));
      bfg_pkg::FN_06: begin
        a = lsr(t, 32'd8 * ((t >> 15) | (t >> 8)));
        b = 32'd20 | lsr((t >> 19) * 32'd5, t) | (t >> 3);
        a = t * (a & b);
      end
      bfg_pkg::FN_07: begin
        a = (((32'd0 - t) & 32'd4095) * (32'd255 & (t * (t & (t >> 13))))) >> 12;
        b = 32'd127 & asr(t * (32'd234 & (t >> 8) & (t >> 3)), 32'd3 & (t >> 14));
        a = a + b;
      end
      bfg_pkg::FN_08: a = t * (lsr(t, (t >> 9) | (t >> 8)) & 63 & (t >> 4));
      bfg_pkg::FN_09: a = ((t >> 6) | t | lsr(t, t >> 16)) * 32'd10 + ((t >> 11) & 7);
      bfg_pkg::FN_FEEDBACK: begin
        echo_state = asr(echo_state, 1) + asr(echo_state, 4)
          + t * (((t >> 16) | (t >> 6)) & (32'd69 & (t >> 9)));
        a = echo_state;
      end
      bfg_pkg::FN_11: a = ((t | (t >> 9) | (t >> 7)) * t) & ((t >> 11) | (t >> 9));
      bfg_pkg::FN_12: a = ((t * 32'd5) & (t >> 7)) | ((t * 32'd3) & asr(t * 32'd4, 10));
      bfg_pkg::FN_13: a = ((t >> 7) | t | (t >> 6)) * 32'd10
                          + 32'd4 * ((t & (t >> 13)) | (t >> 6));
      bfg_pkg::FN_14: begin
        if (t[12]) begin
          a = asr((t * (t ^ (t % 32'd255))) | (t >> 4), 1);
        end else begin
          a = (t >> 3) | (t[13] ? (t << 2) : t);
        end
      end
      bfg_pkg::FN_15: a = ((t * ((t >> 8) | (t >> 9))) & 46 & (t >> 8))
                          ^ ((t & (t >> 13)) | (t >> 6));
      default: a = 0;
    endcase
    return a;
  endfunction

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.time_index <= '0;
      req_bus.func <= bfg_pkg::FN_SILENT_A;
      smp_bus.ready <= 1'b0;
    end else begin
      if (!req_bus.valid || req_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_bus.valid <= 1'b1;
          req_bus.time_index <= pending_q[0].time_index;
          req_bus.func <= pending_q[0].func;
          void'(pending_q.pop_front());
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      smp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken <= req_bus.valid && req_bus.ready;
      if ((req_bus.valid && req_bus.ready) || (smp_bus.valid && smp_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (req_bus.valid && req_bus.ready) begin
        sample_q.push_back(8'(bytebeat_value({1'b0, req_bus.time_index}, req_bus.func)));
        fn_seen[req_bus.func]++;
      end
      if (smp_bus.valid && smp_bus.ready) begin
        sample_count++;
        if (sample_q.size() == 0) begin
          $error("sample: expected none actual %0d", smp_bus.sample);
          fail_count++;
        end else begin
          if (smp_bus.sample !== sample_q[0]) begin
            $error("sample: expected %0d actual %0d", sample_q[0], smp_bus.sample);
            fail_count++;
          end
          void'(sample_q.pop_front());
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic [30:0] t, input logic [3:0] fn);
    request_t r;
    r.time_index = t;
    r.func = fn;
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || req_bus.valid || sample_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    logic [30:0] t;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: t = 31'($urandom_range(32'h0000_ffff));
        1: t = 31'($urandom_range(32'h00ff_ffff));
        default: t = 31'($urandom);
      endcase
      if ($urandom_range(9) == 0) begin
        for (int k = 0; k < 6; k++) begin
          queue_request(t + 31'(k), bfg_pkg::FN_FEEDBACK);
        end
        i += 5;
      end else begin
        queue_request(t, 4'($urandom_range(15)));
      end
    end
    wait_drained();
  endtask

  initial begin
    echo_state = 0;
    fail_count = 0;
    sample_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (fn_seen[i]) fn_seen[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int f = 0; f < 16; f++) begin
      queue_request(31'h7fff_ffff, 4'(f));
    end
    queue_request('0, bfg_pkg::FN_01);
    queue_request(31'h0000_1000, bfg_pkg::FN_14);
    queue_request(31'h0000_2000, bfg_pkg::FN_14);
    queue_request(31'h0000_3fff, bfg_pkg::FN_14);
    queue_request(31'h5555_5555, bfg_pkg::FN_FEEDBACK);
    queue_request(31'h2aaa_aaaa, bfg_pkg::FN_FEEDBACK);
    queue_request(31'h2aaa_aaaa, bfg_pkg::FN_SILENT_B);
    queue_request(31'h7fff_0000, bfg_pkg::FN_FEEDBACK);
    queue_request(31'h0001_f000, bfg_pkg::FN_02);
    wait_drained();

    random_phase(200, 0, 0);
    random_phase(180, 59, 0);
    random_phase(180, 0, 59);
    random_phase(190, 10, 10);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d samples over all sixteen selectors, including feedback runs",
             sample_count);
    $display("idle and stall phases covered; formula 10 requests: %0d", fn_seen[10]);
    if (fail_count == 0 && sample_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/bfg_pkg.sv
design/bfg_if.sv
design/bfg_mul.sv
design/bytebeat_formula_generator.sv
bench/bytebeat_formula_generator_test.sv
